// File: rtl/dsn_pkg.sv
`default_nettype none

package dsn_pkg;

   localparam int unsigned SCORE_W = 32;

   typedef logic [SCORE_W-1:0] score_type;

   // Exchange only when both are non-negative and the left one is smaller
   function automatic logic must_swap(input score_type left, input score_type right);
      logic both_pos;
      both_pos = !left[SCORE_W-1] && !right[SCORE_W-1];
      return both_pos && (left < right);
   endfunction

endpackage

`default_nettype wire

// File: rtl/dsn_ram.sv
`default_nettype none

module dsn_ram
   import dsn_pkg::*;
#(
   parameter int unsigned DEPTH = 16,
   parameter int unsigned AW    = 4
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire score_type     wr_data,
   input  wire logic          rd_en,
   input  wire logic [AW-1:0] rd_addr,
   output score_type          rd_data
);

   score_type mem [DEPTH];
   score_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/descending_sort_nonnegative.sv
// Channel   Dir  tdata                    tuser  tlast
// req_      in   [31:0] score_value       -      is_last
// rsp_      out  [31:0] sorted_value      -      last_out
//
// Beats past MAX_ITEMS are dropped during loading.
// Sorting n >= 2 elements runs in backward bubble passes with one compare per
// cycle, limited by the single read and single write port of the store.
// A list of one element skips the sort and goes straight to readout.
// Each result beat is read, registered and handed off before the next read starts.
// Reset clears the control state only; the store needs no clearing pass.
// Input is accepted only while loading; a held result stalls the readout.
`default_nettype none

module descending_sort_nonnegative
   import dsn_pkg::*;
#(
   parameter int unsigned MAX_ITEMS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] score_value
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] sorted_value
   output logic             rsp_tlast
);

   localparam int unsigned AW = $clog2(MAX_ITEMS);
   localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

   localparam logic [2:0] S_LOAD  = 3'd0;
   localparam logic [2:0] S_PRIME = 3'd1;
   localparam logic [2:0] S_FIRST = 3'd2;
   localparam logic [2:0] S_STEP  = 3'd3;
   localparam logic [2:0] S_TAIL  = 3'd4;
   localparam logic [2:0] S_EMIT  = 3'd5;

   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] start_ff, start_in;
   logic [AW-1:0] pos_ff, pos_in;
   logic [AW-1:0] k_ff, k_in;
   score_type     cur_ff, cur_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          last_pend_ff, last_pend_in;
   logic          rsp_valid_ff, rsp_valid_in;
   score_type     rsp_data_ff;
   logic          rsp_last_ff;

   logic          wr_en, rd_en;
   logic [AW-1:0] wr_addr, rd_addr;
   score_type     wr_data, rd_data;

   logic          req_fire, room, swap;
   logic [CW-1:0] count_next;
   logic [AW-1:0] last_idx;
   logic [AW:0]   pos_p1, pos_p2;

   dsn_ram #(.DEPTH(MAX_ITEMS), .AW(AW)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign req_tready = (state_ff == S_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign room       = (count_ff < CW'(MAX_ITEMS));
   assign count_next = count_ff + CW'(room);
   assign last_idx   = AW'(count_ff - CW'(1));
   assign pos_p1     = {1'b0, pos_ff} + (AW+1)'(1);
   assign pos_p2     = {1'b0, pos_ff} + (AW+1)'(2);
   assign swap       = must_swap(cur_ff, rd_data);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      start_in     = start_ff;
      pos_in       = pos_ff;
      k_in         = k_ff;
      cur_in       = cur_ff;
      rd_pend_in   = 1'b0;
      last_pend_in = last_pend_ff;
      wr_en        = 1'b0;
      wr_addr      = pos_ff;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = start_ff;

      unique case (state_ff)
         S_LOAD: begin
            if (req_fire) begin
               wr_en    = room;
               wr_addr  = AW'(count_ff);
               wr_data  = req_tdata;
               count_in = count_next;
               if (req_tlast) begin
                  k_in     = '0;
                  start_in = AW'(count_next - CW'(2));
                  state_in = (count_next == CW'(1)) ? S_EMIT : S_PRIME;
               end
            end
         end
         S_PRIME: begin
            rd_en    = 1'b1;
            rd_addr  = start_ff;
            state_in = S_FIRST;
         end
         S_FIRST: begin
            cur_in   = rd_data;
            rd_en    = 1'b1;
            rd_addr  = AW'({1'b0, start_ff} + (AW+1)'(1));
            pos_in   = start_ff;
            state_in = S_STEP;
         end
         S_STEP: begin
            // rd_data is the element right of pos; of two non-negatives the larger stays behind
            wr_en   = 1'b1;
            wr_addr = pos_ff;
            wr_data = swap ? rd_data : cur_ff;
            cur_in  = swap ? cur_ff : rd_data;
            if (AW'(pos_p1) == last_idx) begin
               state_in = S_TAIL;
            end else begin
               rd_en   = 1'b1;
               rd_addr = AW'(pos_p2);
               pos_in  = AW'(pos_p1);
            end
         end
         S_TAIL: begin
            wr_en   = 1'b1;
            wr_addr = last_idx;
            wr_data = cur_ff;
            if (start_ff == '0) begin
               state_in = S_EMIT;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = start_ff - AW'(1);
               start_in = start_ff - AW'(1);
               state_in = S_FIRST;
            end
         end
         S_EMIT: begin
            if (!rd_pend_ff && !rsp_valid_ff) begin
               rd_en        = 1'b1;
               rd_addr      = k_ff;
               rd_pend_in   = 1'b1;
               last_pend_in = (k_ff == last_idx);
               if (k_ff == last_idx) begin
                  count_in = '0;
                  state_in = S_LOAD;
               end else begin
                  k_in = k_ff + AW'(1);
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rd_pend_ff) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      start_ff     <= start_in;
      pos_ff       <= pos_in;
      k_ff         <= k_in;
      cur_ff       <= cur_in;
      last_pend_ff <= last_pend_in;
      if (rd_pend_ff) begin
         rsp_data_ff <= rd_data;
         rsp_last_ff <= last_pend_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS))
      else $error("element count beyond store depth");

   a_read_slot_free: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !rsp_valid_ff)
      else $error("readout issued while result register busy");

   a_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_STEP) |-> (pos_ff < last_idx && count_ff >= CW'(2)))
      else $error("compare position past end of list");

   a_emit_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT) |-> (count_ff != '0 && k_ff <= last_idx))
      else $error("readout of an empty list");
`endif

endmodule

`default_nettype wire

// File: dv/tb_descending_sort_nonnegative.sv
`timescale 1ns / 1ps

module tb_descending_sort_nonnegative
   import dsn_pkg::*;
();

   localparam int unsigned DEPTH      = 16;
   localparam int unsigned LIMIT      = 200000;
   localparam int unsigned DRAIN      = 300;
   localparam int unsigned RAND_BEATS = 90;

   typedef struct {
      score_type value;
      logic      last;
   } ranked_beat_type;

   // Predicts the ranked readout of each list and checks the result beats
   class ranking_board_type;
      score_type       held [DEPTH];
      int unsigned     held_n;
      ranked_beat_type ranked_q [$];
      int unsigned     mismatches;
      int unsigned     checked;

      function new();
         held_n     = 0;
         mismatches = 0;
         checked    = 0;
      endfunction

      // Backward bubble passes; negatives act as fixed walls
      function void rank_held();
         int        s;
         int        p;
         score_type t;
         for (s = int'(held_n) - 2; s >= 0; s--) begin
            for (p = s; p < int'(held_n) - 1; p++) begin
               if (!held[p][SCORE_W-1] && !held[p+1][SCORE_W-1] &&
                   $signed(held[p]) < $signed(held[p+1])) begin
                  t         = held[p];
                  held[p]   = held[p+1];
                  held[p+1] = t;
               end
            end
         end
      endfunction

      function void take_score(input score_type v, input logic last);
         ranked_beat_type b;
         int unsigned     k;
         // drop anything past a full store
         if (held_n < DEPTH) begin
            held[held_n] = v;
            held_n++;
         end
         if (last) begin
            rank_held();
            for (k = 0; k < held_n; k++) begin
               b.value = held[k];
               b.last  = (k + 1 == held_n);
               ranked_q.push_back(b);
            end
            held_n = 0;
         end
      endfunction

      function void check_ranked(input score_type v, input logic last);
         ranked_beat_type b;
         checked++;
         if (ranked_q.size() == 0) begin
            $display("%0t: result beat with nothing expected: expected none, actual %h last %b",
                     $time, v, last);
            mismatches++;
            return;
         end
         b = ranked_q.pop_front();
         if (v !== b.value) begin
            $display("%0t: sorted_value mismatch: expected %h, actual %h", $time, b.value, v);
            mismatches++;
         end
         if (last !== b.last) begin
            $display("%0t: last_out mismatch: expected %b, actual %b", $time, b.last, last);
            mismatches++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;   // [31:0] score_value
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [31:0] sorted_value
   logic        rsp_tlast;

   ranking_board_type board = new();
   bit                calm = 1'b0;
   int unsigned       cycles = 0;
   int unsigned       lists_sent = 0;
   int unsigned       beats_sent = 0;

   descending_sort_nonnegative #(
      .MAX_ITEMS(DEPTH)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, board.ranked_q.size());
         $display("status: fail");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         board.check_ranked(rsp_tdata, rsp_tlast);
   end

   // Result side: bursts of ready and stall, always ready once calm
   initial begin
      int span;
      rsp_tready = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_tready <= 1'b1;
            span = $urandom_range(1, 8);
         end else begin
            rsp_tready <= 1'b0;
            span = $urandom_range(1, 5);
         end
         repeat (span) @(posedge clock);
      end
   end

   task automatic send_score(input score_type v, input logic last);
      int gap;
      if (!calm && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         gap = $urandom_range(1, 5);
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= v;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      board.take_score(v, last);
      beats_sent++;
   endtask

   task automatic send_list(input score_type vals [$]);
      int i;
      for (i = 0; i < vals.size(); i++)
         send_score(vals[i], i == vals.size() - 1);
      lists_sent++;
   endtask

   function automatic score_type pick_score();
      score_type v;
      case ($urandom_range(0, 5))
         0: v = score_type'($urandom_range(0, 300));
         1: v = score_type'($urandom);
         2: v = score_type'(-$urandom_range(1, 100000));
         3: v = score_type'($urandom) & 32'h7FFF_FFFF;
         4: case ($urandom_range(0, 3))
               0: v = 32'h0000_0000;
               1: v = 32'h7FFF_FFFF;
               2: v = 32'h8000_0000;
               default: v = 32'hFFFF_FFFF;
            endcase
         default: v = score_type'($urandom_range(1, 4)) << 16;
      endcase
      return v;
   endfunction

   initial begin
      score_type   lst [$];
      int unsigned len;
      int unsigned i;
      int unsigned rand_beats;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tlast  = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single element, then a plain swap at the top of the range
      lst = '{32'h7FFF_FFFF};
      send_list(lst);
      lst = '{32'h0000_0001, 32'h7FFF_FFFF};
      send_list(lst);
      // a negative in the middle keeps the larger value behind it
      lst = '{32'h0003_0000, 32'hFFFF_FFFF, 32'h0009_0000, 32'h0000_0000};
      send_list(lst);
      // overfull list: the flagged beat is dropped but still closes the list
      lst = '{32'h0000_0000, 32'h8000_0000, 32'h0000_0005, 32'h7FFF_FFFF,
              32'hFFFF_0000, 32'h0001_0000, 32'h0001_0000, 32'h0002_0000,
              32'hFFFF_FFFF, 32'h0000_8000, 32'h0000_0001, 32'h7FFF_0000,
              32'h8000_0001, 32'h0000_0003, 32'h0000_0002, 32'h4000_0000,
              32'h1234_5678};
      send_list(lst);

      rand_beats = 0;
      while (rand_beats < RAND_BEATS) begin
         case ($urandom_range(0, 9))
            0:       len = $urandom_range(DEPTH + 1, DEPTH + 4);
            1:       len = $urandom_range(1, 2);
            default: len = $urandom_range(2, DEPTH);
         endcase
         lst.delete();
         for (i = 0; i < len; i++)
            lst.push_back(pick_score());
         // settle into back-to-back traffic for the tail of the run
         if (rand_beats > RAND_BEATS - 25)
            calm = 1'b1;
         send_list(lst);
         rand_beats += len;
      end
      req_tvalid <= 1'b0;

      while (board.ranked_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);

      $display("sent %0d lists in %0d beats (including overfull and single-element lists)",
               lists_sent, beats_sent);
      $display("checked %0d sorted beats, %0d mismatches", board.checked, board.mismatches);
      if (board.mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// File: descending_sort_nonnegative.f
rtl/dsn_pkg.sv
rtl/dsn_ram.sv
rtl/descending_sort_nonnegative.sv
dv/tb_descending_sort_nonnegative.sv
